@@ rtl/core/dedup_job_fifo_unit_assert.svh @@
// ---------------------------------------------------------------------------
// dedup_job_fifo_unit assertion macros
// concurrent property wrappers clocked on clk, disabled during rst
// ---------------------------------------------------------------------------
`ifndef DEDUP_JOB_FIFO_UNIT_ASSERT_SVH
`define DEDUP_JOB_FIFO_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define DJF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DJF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/djf_pkg.sv @@
// ---------------------------------------------------------------------------
// djf_pkg
// shared types for the duplicate-rejecting job queue
// ---------------------------------------------------------------------------
package djf_pkg;

  typedef enum logic [1:0] {
    FN_SCHEDULE  = 2'd0,
    FN_MARK_DONE = 2'd1,
    FN_RETIRE    = 2'd2,
    FN_CLEAR     = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_POP_RD,
    ST_FINISH
  } state_t;

  // one stored job
  typedef struct packed {
    logic [15:0] msg;
    logic [7:0]  cmd;
    logic        kind;
  } job_t;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic scan_step;
    logic pop_read;
    logic commit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic scan_more;
    logic rd_pend;
    logic dup;
    logic res_free;
  } dp_stat_t;

endpackage

@@ rtl/core/djf_ctrl.sv @@
// ---------------------------------------------------------------------------
// djf_ctrl
// sequencer for accept, duplicate scan, head read and commit
// ---------------------------------------------------------------------------
module djf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        func,
  input  djf_pkg::dp_stat_t stat,
  output djf_pkg::dp_cmd_t  cmd
);

  djf_pkg::state_t state;
  djf_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= djf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      djf_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (djf_pkg::func_t'(func))
            djf_pkg::FN_SCHEDULE: state_next = djf_pkg::ST_SCAN;
            djf_pkg::FN_RETIRE:   state_next = djf_pkg::ST_POP_RD;
            default:              state_next = djf_pkg::ST_FINISH;
          endcase
        end
      end
      djf_pkg::ST_SCAN: begin
        if (stat.full || stat.dup) begin
          state_next = djf_pkg::ST_FINISH;
        end else if (!stat.scan_more && !stat.rd_pend) begin
          state_next = djf_pkg::ST_FINISH;
        end
      end
      djf_pkg::ST_POP_RD: begin
        state_next = djf_pkg::ST_FINISH;
      end
      djf_pkg::ST_FINISH: begin
        if (stat.res_free) begin
          state_next = djf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = djf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.start     = 1'b0;
    cmd.scan_step = 1'b0;
    cmd.pop_read  = 1'b0;
    cmd.commit    = 1'b0;
    case (state)
      djf_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      djf_pkg::ST_SCAN: begin
        cmd.scan_step = !stat.full && !stat.dup && stat.scan_more;
      end
      djf_pkg::ST_POP_RD: begin
        cmd.pop_read = 1'b1;
      end
      djf_pkg::ST_FINISH: begin
        cmd.commit = stat.res_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/core/djf_dpath.sv @@
// ---------------------------------------------------------------------------
// djf_dpath
// job memory, queue pointers, scan compare and result register
// ---------------------------------------------------------------------------
module djf_dpath #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        func,
  input  logic [15:0]       msg_handle,
  input  logic [7:0]        cmd_byte,
  input  logic              is_data,
  input  djf_pkg::dp_cmd_t  cmd,
  output djf_pkg::dp_stat_t stat,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              ok,
  output logic [15:0]       out_msg_handle,
  output logic [7:0]        out_cmd_byte,
  output logic              out_is_data,
  output logic [3:0]        fill_count
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int OW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);
  localparam logic [OW-1:0] FULL_OCC  = OW'(QUEUE_DEPTH);

  djf_pkg::job_t mem [QUEUE_DEPTH];

  // request and queue state
  djf_pkg::func_t req_func;
  djf_pkg::job_t  req_job;
  logic [PW-1:0]  head;
  logic [PW-1:0]  tail;
  logic [OW-1:0]  occ;
  logic           head_done;

  // scan state
  logic [PW-1:0]  scan_ptr;
  logic [OW-1:0]  scan_cnt;
  logic           rd_pend;
  logic           rd_first;
  djf_pkg::job_t  rd_word;
  logic           dup;

  // commit next values
  logic [PW-1:0]  head_next;
  logic [PW-1:0]  tail_next;
  logic [OW-1:0]  occ_next;
  logic           head_done_next;
  logic           res_ok;
  logic           sched_ok;
  logic           wr_en;
  logic           rd_en;
  logic [PW-1:0]  rd_addr;
  logic [OW+3:0]  occ_ext;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  assign stat.full      = (occ == FULL_OCC);
  assign stat.scan_more = (scan_cnt < occ);
  assign stat.rd_pend   = rd_pend;
  assign stat.dup       = dup;
  assign stat.res_free  = !out_valid || out_ready;

  assign sched_ok = !stat.full && !dup;
  assign wr_en    = cmd.commit && (req_func == djf_pkg::FN_SCHEDULE) && sched_ok;
  assign rd_en    = cmd.scan_step || cmd.pop_read;
  assign rd_addr  = cmd.pop_read ? head : scan_ptr;

  // job memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail] <= req_job;
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  always_comb begin
    head_next      = head;
    tail_next      = tail;
    occ_next       = occ;
    head_done_next = head_done;
    res_ok         = 1'b0;
    case (req_func)
      djf_pkg::FN_SCHEDULE: begin
        if (sched_ok) begin
          tail_next = ptr_inc(tail);
          occ_next  = occ + 1'b1;
          res_ok    = 1'b1;
        end
      end
      djf_pkg::FN_MARK_DONE: begin
        if (occ != '0) begin
          head_done_next = 1'b1;
        end
      end
      djf_pkg::FN_RETIRE: begin
        if ((occ != '0) && head_done) begin
          res_ok         = 1'b1;
          head_done_next = 1'b0;
          occ_next       = occ - 1'b1;
          if (occ == OW'(1)) begin
            head_next = '0;
            tail_next = '0;
          end else begin
            head_next = ptr_inc(head);
          end
        end
      end
      default: begin
        head_next      = '0;
        tail_next      = '0;
        occ_next       = '0;
        head_done_next = 1'b0;
      end
    endcase
  end

  assign occ_ext = {4'b0, occ_next};

  // queue pointers and scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      occ       <= '0;
      head_done <= 1'b0;
      rd_pend   <= 1'b0;
      dup       <= 1'b0;
      scan_cnt  <= '0;
      scan_ptr  <= '0;
      out_valid <= 1'b0;
    end else begin
      rd_pend <= cmd.scan_step;
      if (cmd.start) begin
        scan_ptr <= head;
        scan_cnt <= '0;
        dup      <= 1'b0;
      end else begin
        if (cmd.scan_step) begin
          scan_ptr <= ptr_inc(scan_ptr);
          scan_cnt <= scan_cnt + 1'b1;
        end
        // only the head entry can be completed rather than scheduled
        if (rd_pend && (rd_word == req_job) && !(rd_first && head_done)) begin
          dup <= 1'b1;
        end
      end
      if (cmd.commit) begin
        head      <= head_next;
        tail      <= tail_next;
        occ       <= occ_next;
        head_done <= head_done_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_func <= djf_pkg::func_t'(func);
      req_job  <= '{msg: msg_handle, cmd: cmd_byte, kind: is_data};
    end
    if (cmd.scan_step) begin
      rd_first <= (scan_cnt == '0);
    end
    if (cmd.commit) begin
      ok         <= res_ok;
      fill_count <= occ_ext[3:0];
      if (res_ok && (req_func == djf_pkg::FN_RETIRE)) begin
        out_msg_handle <= rd_word.msg;
        out_cmd_byte   <= rd_word.cmd;
        out_is_data    <= rd_word.kind;
      end else begin
        out_msg_handle <= '0;
        out_cmd_byte   <= '0;
        out_is_data    <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/dedup_job_fifo_unit.sv @@
// ---------------------------------------------------------------------------
// dedup_job_fifo_unit
// circular job queue that refuses a job already waiting as scheduled
// ---------------------------------------------------------------------------
// usage:
//   request channel (in_valid/in_ready) carries func, msg_handle, cmd_byte,
//   is_data; every request transfer yields exactly one response transfer
//   (out_valid/out_ready) with ok, the retired job fields and fill_count
//   func: schedule at the tail, mark the head done, retire a done head, clear
//   requests are handled one at a time; in_ready is high only when idle
// sequence from request transfer to response valid:
//   schedule: a duplicate scan reads one stored job per cycle from the single
//     job memory read port, registered, and compares each with the request;
//     the commit follows the scan; an empty or full queue reads no stored job,
//     and a duplicate ends the scan early
//   retire: head read from the job memory, then commit
//   mark done and clear: straight to the commit
//   a new request is taken the cycle after the response is loaded, so it
//   overlaps with a response still waiting in the output register
// reset: rst (synchronous) empties the queue and drops any pending response
// stall: while out_ready is low the response holds; the next request runs
//   up to its commit and waits there for the output register to free up
// ---------------------------------------------------------------------------
module dedup_job_fifo_unit #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [15:0] msg_handle,
  input  logic [7:0]  cmd_byte,
  input  logic        is_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        ok,
  output logic [15:0] out_msg_handle,
  output logic [7:0]  out_cmd_byte,
  output logic        out_is_data,
  output logic [3:0]  fill_count
);

  // command and status between sequencer and datapath
  djf_pkg::dp_cmd_t  dp_cmd;
  djf_pkg::dp_stat_t dp_stat;

  djf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (func),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  // job memory, pointers, scan compare and response register
  djf_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .func           (func),
    .msg_handle     (msg_handle),
    .cmd_byte       (cmd_byte),
    .is_data        (is_data),
    .cmd            (dp_cmd),
    .stat           (dp_stat),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .ok             (ok),
    .out_msg_handle (out_msg_handle),
    .out_cmd_byte   (out_cmd_byte),
    .out_is_data    (out_is_data),
    .fill_count     (fill_count)
  );

endmodule

@@ rtl/core/djf_checker.sv @@
// ---------------------------------------------------------------------------
// djf_checker
// port-level checks for dedup_job_fifo_unit
// ---------------------------------------------------------------------------
`include "dedup_job_fifo_unit_assert.svh"

module djf_checker #(
  parameter int QUEUE_DEPTH = 8
) (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        ok,
  input logic [15:0] out_msg_handle,
  input logic [7:0]  out_cmd_byte,
  input logic        out_is_data,
  input logic [3:0]  fill_count
);

  `DJF_ASSERT_NEXT(a_rsp_hold, out_valid && !out_ready,
    out_valid && $stable(ok) && $stable(out_msg_handle) && $stable(out_cmd_byte)
      && $stable(fill_count),
    "response changed while stalled")

  `DJF_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "request taken while busy")

  `DJF_ASSERT_SAME(a_fill_bound, out_valid,
    (QUEUE_DEPTH > 15) || (int'(fill_count) <= QUEUE_DEPTH),
    "fill count beyond queue depth")

  `DJF_ASSERT_SAME(a_fail_zero, out_valid && !ok,
    (out_msg_handle == 16'd0) && (out_cmd_byte == 8'd0) && !out_is_data,
    "job fields set on refused request")

endmodule

bind dedup_job_fifo_unit djf_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_djf_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .ok             (ok),
  .out_msg_handle (out_msg_handle),
  .out_cmd_byte   (out_cmd_byte),
  .out_is_data    (out_is_data),
  .fill_count     (fill_count)
);

@@ test/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the duplicate-rejecting circular job queue
// ---------------------------------------------------------------------------
// a driver feeds request transfers from a backlog filled at time zero, a
// shadow copy of the queue computes the response each request should give,
// and a monitor compares every response transfer against the oldest pending
// prediction; both sides idle at random and the response side holds off once
// for a long stretch so that the unit backs up and stalls its request side
// ---------------------------------------------------------------------------
module tb_top;

  localparam int DEPTH       = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_JOBS = 450;
  localparam int MAX_REPORTS = 10;

  // per-slot status held by the shadow queue
  typedef enum logic [1:0] {
    SLOT_FREE,
    SLOT_QUEUED,
    SLOT_DONE
  } slot_state_t;

  typedef struct packed {
    djf_pkg::func_t fn;
    logic [15:0]    msg;
    logic [7:0]     cmd;
    logic           kind;
  } job_req_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] msg;
    logic [7:0]  cmd;
    logic        kind;
    logic [3:0]  fill;
  } job_resp_t;

  logic        clk            = 1'b0;
  logic        rst            = 1'b1;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic [1:0]  func           = djf_pkg::FN_SCHEDULE;
  logic [15:0] msg_handle     = '0;
  logic [7:0]  cmd_byte       = '0;
  logic        is_data        = 1'b0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic        ok;
  logic [15:0] out_msg_handle;
  logic [7:0]  out_cmd_byte;
  logic        out_is_data;
  logic [3:0]  fill_count;

  dedup_job_fifo_unit #(
    .QUEUE_DEPTH(DEPTH)
  ) u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .msg_handle     (msg_handle),
    .cmd_byte       (cmd_byte),
    .is_data        (is_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .ok             (ok),
    .out_msg_handle (out_msg_handle),
    .out_cmd_byte   (out_cmd_byte),
    .out_is_data    (out_is_data),
    .fill_count     (fill_count)
  );

  always #5 clk = ~clk;

  // requests waiting to be offered, and responses predicted but not yet seen
  job_req_t  request_backlog[$];
  job_resp_t pending_responses[$];

  // shadow copy of the job queue
  logic [15:0] shadow_msg[DEPTH];
  logic [7:0]  shadow_cmd[DEPTH];
  logic        shadow_kind[DEPTH];
  slot_state_t shadow_state[DEPTH];
  logic [2:0]  shadow_head;
  logic [2:0]  shadow_tail;
  logic [3:0]  shadow_count;

  int fail_count = 0;
  int cycle_count = 0;
  int sent_count = 0;
  int total_jobs = 0;

  // advance the shadow queue by one request and return the response it owes
  function automatic job_resp_t apply_job_request(input job_req_t r);
    job_resp_t  rsp;
    logic       dup;
    logic [2:0] s;
    int         i;
    rsp = '0;
    case (r.fn)
      djf_pkg::FN_SCHEDULE: begin
        // only jobs still waiting as scheduled block an identical one
        dup = 1'b0;
        for (i = 0; i < shadow_count; i++) begin
          s = shadow_head + 3'(i);
          if (shadow_state[s] == SLOT_QUEUED && shadow_msg[s] == r.msg &&
              shadow_cmd[s] == r.cmd && shadow_kind[s] == r.kind)
            dup = 1'b1;
        end
        if (shadow_count < DEPTH && !dup && shadow_state[shadow_tail] == SLOT_FREE) begin
          shadow_state[shadow_tail] = SLOT_QUEUED;
          shadow_msg[shadow_tail]   = r.msg;
          shadow_cmd[shadow_tail]   = r.cmd;
          shadow_kind[shadow_tail]  = r.kind;
          shadow_tail  = shadow_tail + 3'd1;
          shadow_count = shadow_count + 4'd1;
          rsp.ok = 1'b1;
        end
      end
      djf_pkg::FN_MARK_DONE: begin
        // never reports ok, even when the head moves to done
        if (shadow_count != 0 && shadow_state[shadow_head] == SLOT_QUEUED)
          shadow_state[shadow_head] = SLOT_DONE;
      end
      djf_pkg::FN_RETIRE: begin
        if (shadow_count != 0 && shadow_state[shadow_head] == SLOT_DONE) begin
          rsp.msg  = shadow_msg[shadow_head];
          rsp.cmd  = shadow_cmd[shadow_head];
          rsp.kind = shadow_kind[shadow_head];
          rsp.ok   = 1'b1;
          shadow_state[shadow_head] = SLOT_FREE;
          shadow_head  = shadow_head + 3'd1;
          shadow_count = shadow_count - 4'd1;
          // a drained queue starts over at slot zero
          if (shadow_count == 0) begin
            shadow_head = '0;
            shadow_tail = '0;
          end
        end
      end
      default: begin
        // clear keeps the stored data flags
        for (i = 0; i < DEPTH; i++) begin
          shadow_msg[i]   = '0;
          shadow_cmd[i]   = '0;
          shadow_state[i] = SLOT_FREE;
        end
        shadow_head  = '0;
        shadow_tail  = '0;
        shadow_count = '0;
      end
    endcase
    rsp.fill = shadow_count;
    return rsp;
  endfunction

  // idle length between transfers: runs of back-to-back traffic mix at random
  // with runs of mostly short gaps and a few long ones
  function automatic int pick_idle(inout int run_left, inout bit run_busy);
    int r;
    if (run_left == 0) begin
      run_busy = ($urandom_range(0, 2) == 0);
      run_left = $urandom_range(10, 50);
    end
    run_left--;
    if (run_busy)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 88)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic push_job(input djf_pkg::func_t f, input logic [15:0] m,
                          input logic [7:0] c, input logic k);
    job_req_t r;
    r.fn   = f;
    r.msg  = m;
    r.cmd  = c;
    r.kind = k;
    request_backlog.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // request driver: holds each request until its transfer, predicts the
  // response at the transfer, then waits out a random gap
  // ---------------------------------------------------------------------------
  job_req_t cur_req;
  int       send_gap = 0;
  int       send_run_left = 0;
  bit       send_run_busy = 1'b0;

  always @(posedge clk) begin
    logic offer;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      offer = in_valid;
      if (in_valid && in_ready) begin
        pending_responses.push_back(apply_job_request(cur_req));
        sent_count++;
        offer = 1'b0;
        send_gap = pick_idle(send_run_left, send_run_busy);
      end
      // a zero gap loads the next request in the same cycle, so valid stays up
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (request_backlog.size() != 0) begin
          cur_req = request_backlog.pop_front();
          func       <= cur_req.fn;
          msg_handle <= cur_req.msg;
          cmd_byte   <= cur_req.cmd;
          is_data    <= cur_req.kind;
          offer = 1'b1;
        end
      end
      in_valid <= offer;
    end
  end

  // ---------------------------------------------------------------------------
  // response side readiness: random stalls after each transfer, plus one long
  // hold-off once traffic is well under way so the unit fills and backs up
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  int holdoff_left = 0;
  int resp_drained = 0;
  int rcv_run_left = 0;
  bit rcv_run_busy = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
      holdoff_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        resp_drained++;
        stall_left = pick_idle(rcv_run_left, rcv_run_busy);
        if (resp_drained == 120)
          holdoff_left = 400;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every response transfer is checked against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    job_resp_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_responses.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: response transfer with no request outstanding", $time);
      end else begin
        want = pending_responses.pop_front();
        if (ok !== want.ok || out_msg_handle !== want.msg || out_cmd_byte !== want.cmd ||
            out_is_data !== want.kind || fill_count !== want.fill) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("%0t: response mismatch exp ok=%0b msg=%h cmd=%h data=%0b fill=%0d",
                     $time, want.ok, want.msg, want.cmd, want.kind, want.fill);
            $display("%0t: response mismatch got ok=%0b msg=%h cmd=%h data=%0b fill=%0d",
                     $time, ok, out_msg_handle, out_cmd_byte, out_is_data, fill_count);
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int pick;
    int burst;
    int i;

    for (i = 0; i < DEPTH; i++) begin
      shadow_msg[i]   = '0;
      shadow_cmd[i]   = '0;
      shadow_kind[i]  = 1'b0;
      shadow_state[i] = SLOT_FREE;
    end
    shadow_head  = '0;
    shadow_tail  = '0;
    shadow_count = '0;

    // directed: empty-queue corner cases first
    push_job(djf_pkg::FN_RETIRE, 16'hFFFF, 8'hFF, 1'b1);
    push_job(djf_pkg::FN_MARK_DONE, 16'hFFFF, 8'hFF, 1'b1);
    // extremes, an exact duplicate, and one differing only in the data flag
    push_job(djf_pkg::FN_SCHEDULE, 16'hFFFF, 8'hFF, 1'b1);
    push_job(djf_pkg::FN_SCHEDULE, 16'hFFFF, 8'hFF, 1'b1);
    push_job(djf_pkg::FN_SCHEDULE, 16'h0000, 8'h00, 1'b0);
    push_job(djf_pkg::FN_SCHEDULE, 16'hFFFF, 8'hFF, 1'b0);
    // a completed head no longer blocks an identical job
    push_job(djf_pkg::FN_MARK_DONE, 16'h0000, 8'h00, 1'b0);
    push_job(djf_pkg::FN_SCHEDULE, 16'hFFFF, 8'hFF, 1'b1);
    // marking a head already done changes nothing
    push_job(djf_pkg::FN_MARK_DONE, 16'h0000, 8'h00, 1'b0);
    push_job(djf_pkg::FN_RETIRE, 16'h0000, 8'h00, 1'b0);
    // head still only scheduled, so the retire is refused
    push_job(djf_pkg::FN_RETIRE, 16'h0000, 8'h00, 1'b0);
    // fill to the top, then one more is refused as full
    push_job(djf_pkg::FN_SCHEDULE, 16'h5555, 8'hAA, 1'b1);
    push_job(djf_pkg::FN_SCHEDULE, 16'hAAAA, 8'h55, 1'b0);
    push_job(djf_pkg::FN_SCHEDULE, 16'h8001, 8'h81, 1'b1);
    push_job(djf_pkg::FN_SCHEDULE, 16'h7FFE, 8'h7E, 1'b0);
    push_job(djf_pkg::FN_SCHEDULE, 16'h1234, 8'h5A, 1'b1);
    push_job(djf_pkg::FN_SCHEDULE, 16'h4321, 8'hA5, 1'b0);
    // pop one and push one so the tail reuses the slot just freed
    push_job(djf_pkg::FN_MARK_DONE, 16'h0000, 8'h00, 1'b0);
    push_job(djf_pkg::FN_RETIRE, 16'h0000, 8'h00, 1'b0);
    push_job(djf_pkg::FN_SCHEDULE, 16'hC3C3, 8'h3C, 1'b1);
    // clear a full queue, then a retire finds nothing
    push_job(djf_pkg::FN_CLEAR, 16'hFFFF, 8'hFF, 1'b1);
    push_job(djf_pkg::FN_RETIRE, 16'h0000, 8'h00, 1'b0);
    // single job through its whole life, leaving the queue drained
    push_job(djf_pkg::FN_SCHEDULE, 16'hA5A5, 8'h5A, 1'b1);
    push_job(djf_pkg::FN_MARK_DONE, 16'h0000, 8'h00, 1'b0);
    push_job(djf_pkg::FN_RETIRE, 16'h0000, 8'h00, 1'b0);

    // random: bursts of schedules, handle and command often from a tiny pool, so
    // that duplicates are common, runs of mark/retire, rare clears and noise
    burst = request_backlog.size() + RANDOM_JOBS;
    while (request_backlog.size() < burst) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        repeat ($urandom_range(1, 9))
          push_job(djf_pkg::FN_SCHEDULE,
                   $urandom_range(0, 1) ? 16'($urandom_range(0, 3)) : 16'($urandom),
                   $urandom_range(0, 1) ? 8'($urandom_range(0, 1)) : 8'($urandom),
                   1'($urandom));
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 5) != 0)
            push_job(djf_pkg::FN_MARK_DONE, 16'($urandom), 8'($urandom), 1'($urandom));
          if ($urandom_range(0, 5) != 0)
            push_job(djf_pkg::FN_RETIRE, 16'($urandom), 8'($urandom), 1'($urandom));
        end
      end else if (pick < 97) begin
        push_job(djf_pkg::func_t'($urandom_range(0, 3)), 16'($urandom), 8'($urandom),
                 1'($urandom));
      end else begin
        push_job(djf_pkg::FN_CLEAR, 16'($urandom), 8'($urandom), 1'($urandom));
      end
    end
    total_jobs = request_backlog.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // every request transferred, then every response seen, then a short drain
    while (sent_count < total_jobs)
      @(posedge clk);
    while (pending_responses.size() != 0)
      @(posedge clk);
    repeat (30) @(posedge clk);

    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/djf_pkg.sv
rtl/core/djf_ctrl.sv
rtl/core/djf_dpath.sv
rtl/core/dedup_job_fifo_unit.sv
rtl/core/djf_checker.sv
test/tb_top.sv
